@@ sv/rcl_pkg.sv @@
// Package for the riff/aiff chunk locator.
// Holds the parse phase type, container tags and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcl_pkg;

  // parse phases of the container walk
  typedef enum logic [2:0] {
    PH_OUTER_TAG = 3'd0,
    PH_OUTER_LEN = 3'd1,
    PH_FORM_TYPE = 3'd2,
    PH_CHUNK_TAG = 3'd3,
    PH_CHUNK_LEN = 3'd4,
    PH_SKIP      = 3'd5,
    PH_DONE      = 3'd6
  } phase_t;

  // four-character tags, first file byte in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FORM = 32'h4D52_4F46;
  localparam logic [31:0] TAG_AIFF = 32'h4646_4941;
  localparam logic [31:0] TAG_AIFC = 32'h4346_4941;

  // configuration register indexes
  localparam logic CFG_CONTAINER_FORMAT = 1'b0;
  localparam logic CFG_TARGET_TAG       = 1'b1;

  // field widths
  localparam int unsigned POS_W    = 33;
  localparam int unsigned HDR_W    = 34;
  localparam int unsigned OUT_DATA_W = 40;

  // fixed header offsets
  localparam logic [POS_W-1:0] FORM_TYPE_OFFSET  = 33'd8;
  localparam logic [HDR_W-1:0] FIRST_CHUNK_OFFSET = 34'd12;

  // one result transaction
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] chunk_offset;
  } result_t;

endpackage : rcl_pkg

`default_nettype wire

@@ sv/riff_aiff_chunk_locator_unit.sv @@
// Chunk locator top level: walks a RIFF/WAVE or FORM/AIFF byte stream and
// reports the offset of the chunk whose tag equals the configured target.
// Depends on rcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input stream: one file byte per transaction on s_tdata, s_tlast set on the
//   last byte of a file. Output stream: one result transaction per file,
//   m_tuser = found, m_tdata = chunk offset (zero when not found).
//   Configuration: cfg_write_enable with cfg_index 0 writes container_format
//   (0 = RIFF/WAVE little-endian, 1 = FORM/AIFF big-endian), cfg_index 1 writes
//   target_tag (first tag byte in the low byte). Write only while idle.
// Timing
//   One byte is accepted every cycle while s_tready is high. Each byte goes
//   through a single level of compare/shift/add logic into the walk registers;
//   the widest path is the 34-bit next-header add and compare against the
//   container end. A result is registered into the output or skid register.
// Stall and reset
//   Results go to an output register backed by one skid register; s_tready
//   drops only while the skid register holds a result, so the input keeps
//   flowing while one result waits. Bytes after a result are dropped until
//   s_tlast, which also clears the walk. rst (synchronous, active high)
//   clears the walk, the configuration registers and both result valid flags.
module riff_aiff_chunk_locator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_file
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [rcl_pkg::OUT_DATA_W-1:0] m_tdata,  // [32:0] chunk_offset, [39:33] zero
  output logic             m_tuser,   // [0] found
  // configuration
  input  wire logic        cfg_write_enable,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rcl_pkg::*;

  // configuration registers
  logic        container_format;
  logic [31:0] target_tag;

  // walk state
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [31:0]        word_assembler, word_assembler_next;
  logic [POS_W-1:0]   container_end, container_end_next;
  logic [HDR_W-1:0]   next_header, next_header_next;

  // result registers
  result_t out_res, skid_res;
  logic    out_valid, skid_valid;

  logic    s_accept, m_pop, emit;
  result_t res_new;

  // datapath helpers
  logic [1:0]       word_idx;
  logic             aiff;
  logic [31:0]      word_in;
  logic [HDR_W-1:0] pos_inc;
  logic [HDR_W-1:0] nxt_hdr;
  logic             form_ok;

  assign aiff     = container_format;
  assign s_tready = !skid_valid;
  assign s_accept = s_tvalid && s_tready;
  assign m_pop    = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.found;
  assign m_tdata  = {{(OUT_DATA_W-POS_W){1'b0}}, out_res.chunk_offset};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      container_format <= 1'b0;
      target_tag       <= 32'd0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_CONTAINER_FORMAT: container_format <= cfg_data[0];
        CFG_TARGET_TAG:       target_tag       <= cfg_data;
        default:              ;
      endcase
    end
  end

  // byte index within the current four-byte field
  assign word_idx = byte_position[1:0] - next_header[1:0];
  assign pos_inc  = {1'b0, byte_position} + {{(HDR_W-1){1'b0}}, 1'b1};

  // tags always assemble little-endian, aiff lengths big-endian
  always_comb begin
    if (aiff && (phase == PH_OUTER_LEN || phase == PH_CHUNK_LEN)) begin
      word_in = {word_assembler[23:0], s_tdata};
    end else begin
      word_in = {s_tdata, word_assembler[31:8]};
    end
  end

  // next chunk header: header + 8 + length, plus a pad byte for odd wav lengths
  assign nxt_hdr = next_header + {{(HDR_W-4){1'b0}}, 4'd8} + {2'b00, word_in}
                 + {{(HDR_W-1){1'b0}}, (!aiff && word_in[0])};

  assign form_ok = aiff ? (word_in == TAG_AIFF || word_in == TAG_AIFC)
                        : (word_in == TAG_WAVE);

  // walk step for one accepted byte
  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    word_assembler_next = word_assembler;
    container_end_next  = container_end;
    next_header_next    = next_header;
    emit                = 1'b0;
    res_new.found        = 1'b0;
    res_new.chunk_offset = '0;

    if (s_accept) begin
      case (phase)
        PH_OUTER_TAG, PH_OUTER_LEN, PH_FORM_TYPE, PH_CHUNK_TAG, PH_CHUNK_LEN: begin
          word_assembler_next = word_in;
          if (word_idx == 2'd3) begin
            case (phase)
              PH_OUTER_TAG: begin
                if (word_in != (aiff ? TAG_FORM : TAG_RIFF)) begin
                  emit = 1'b1;
                end else if (target_tag == word_in) begin
                  emit          = 1'b1;
                  res_new.found = 1'b1;
                end else begin
                  phase_next = PH_OUTER_LEN;
                end
              end
              PH_OUTER_LEN: begin
                if (aiff && word_in[31]) begin
                  container_end_next = '0;
                end else begin
                  container_end_next = {1'b0, word_in} + FORM_TYPE_OFFSET;
                end
                phase_next = PH_FORM_TYPE;
              end
              PH_FORM_TYPE: begin
                if (!form_ok) begin
                  emit = 1'b1;
                end else if (target_tag == word_in) begin
                  emit                 = 1'b1;
                  res_new.found        = 1'b1;
                  res_new.chunk_offset = FORM_TYPE_OFFSET;
                end else begin
                  next_header_next = FIRST_CHUNK_OFFSET;
                  if (FIRST_CHUNK_OFFSET >= {1'b0, container_end}) begin
                    emit = 1'b1;
                  end else begin
                    phase_next = PH_CHUNK_TAG;
                  end
                end
              end
              PH_CHUNK_TAG: begin
                if (word_in == target_tag) begin
                  emit                 = 1'b1;
                  res_new.found        = 1'b1;
                  res_new.chunk_offset = next_header[POS_W-1:0];
                end else begin
                  phase_next = PH_CHUNK_LEN;
                end
              end
              default: begin
                // chunk length complete
                if (nxt_hdr >= {1'b0, container_end}) begin
                  emit = 1'b1;
                end else begin
                  next_header_next = nxt_hdr;
                  phase_next = (nxt_hdr == pos_inc) ? PH_CHUNK_TAG : PH_SKIP;
                end
              end
            endcase
          end
        end
        PH_SKIP: begin
          if (pos_inc == next_header) begin
            phase_next = PH_CHUNK_TAG;
          end
        end
        default: ;
      endcase

      if (emit) begin
        phase_next = PH_DONE;
      end

      // end of file: report not found if still walking, then clear the walk
      if (s_tlast) begin
        if (!emit && phase_next != PH_DONE) begin
          emit                 = 1'b1;
          res_new.found        = 1'b0;
          res_new.chunk_offset = '0;
        end
        phase_next          = PH_OUTER_TAG;
        byte_position_next  = '0;
        word_assembler_next = '0;
        container_end_next  = '0;
        next_header_next    = '0;
      end else begin
        byte_position_next = pos_inc[POS_W-1:0];
      end
    end
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_OUTER_TAG;
      byte_position  <= '0;
      word_assembler <= '0;
      container_end  <= '0;
      next_header    <= '0;
    end else begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      word_assembler <= word_assembler_next;
      container_end  <= container_end_next;
      next_header    <= next_header_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_pop) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (emit) begin
        out_res <= res_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid) begin
        out_res   <= res_new;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

  // skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // a not-found result always carries a zero offset
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.found) |-> (out_res.chunk_offset == '0))
    else $error("not-found result with nonzero offset");

  // the end-of-file byte leaves a clean walk
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tlast) |=> (phase == PH_OUTER_TAG && byte_position == '0
                               && next_header == '0))
    else $error("walk state not cleared after end of file");

  // no second result once a file is decided
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (s_accept && phase == PH_DONE) |-> !emit)
    else $error("result produced after the file was already decided");

  // a result can never arrive while both result registers are full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && skid_valid && !m_tready) |=> (out_valid && skid_valid))
    else $error("result registers lost a result under stall");

endmodule : riff_aiff_chunk_locator_unit

`default_nettype wire
